FILE: rtl/keyed_usage_hash_aggregator_assert.svh
// Assertion macros for the keyed usage hash aggregator.
`ifndef KEYED_USAGE_HASH_AGGREGATOR_ASSERT_SVH
`define KEYED_USAGE_HASH_AGGREGATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KHAGG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("khagg assertion failed");

// Next-cycle implication.
`define KHAGG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("khagg assertion failed");

`endif

FILE: rtl/khagg_pkg.sv
// Shared types and constants of the keyed usage hash aggregator.
package khagg_pkg;

  localparam int TABLE_SLOTS_DEFAULT = 4096;
  localparam int SLOT_FIELD_W        = 12;

  localparam logic [31:0] HASH_MUL32 = 32'h61C88647;
  localparam logic [63:0] HASH_MUL64 = 64'h61C8864680B583EB;

  localparam logic [1:0] ADDR_GROUP_BY_ROOT_ONLY = 2'd0;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_SUMMED    = 3'd1,
    ST_SAME      = 3'd2,
    ST_FULL      = 3'd3,
    ST_ZERO_ROOT = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_USED      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_HASH,
    S_PROBE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic                    action;
    logic [63:0]             extent_address;
    logic [63:0]             owner_root;
    logic [63:0]             object_id;
    logic [63:0]             extent_bytes;
    logic [SLOT_FIELD_W-1:0] slot_to_read;
  } item_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot_index;
    logic [63:0]             entry_root;
    logic [63:0]             entry_object;
    logic [63:0]             entry_total;
  } result_t;

  typedef struct packed {
    logic [63:0] root;
    logic [63:0] object;
    logic [63:0] last_extent;
    logic [63:0] total;
  } entry_t;

endpackage

FILE: rtl/khagg_mem.sv
// Slot table: one write port, one registered read port.
module khagg_mem #(
  parameter int TABLE_SLOTS = khagg_pkg::TABLE_SLOTS_DEFAULT,
  localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  khagg_pkg::entry_t   wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output khagg_pkg::entry_t   rdata
);

  khagg_pkg::entry_t mem [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/khagg_hash.sv
// Home slot hash: registered truncated products, XORed on the way out.
module khagg_hash #(
  parameter int TABLE_SLOTS = khagg_pkg::TABLE_SLOTS_DEFAULT,
  localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
  input  logic             clk,
  input  logic             load,
  input  logic [63:0]      root,
  input  logic [63:0]      object,
  output logic [IDX_W-1:0] home
);

  // Low bits of a product depend only on the low bits of its operands.
  localparam logic [IDX_W-1:0] K_ROOT = IDX_W'(khagg_pkg::HASH_MUL32);
  localparam logic [IDX_W-1:0] K_OBJ  = IDX_W'(khagg_pkg::HASH_MUL64);

  logic [IDX_W-1:0] prod_root;
  logic [IDX_W-1:0] prod_obj;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_root <= root[IDX_W-1:0] * K_ROOT;
      prod_obj  <= object[IDX_W-1:0] * K_OBJ;
    end
  end

  assign home = prod_root ^ prod_obj;

endmodule

FILE: rtl/keyed_usage_hash_aggregator.sv
// Top level: probe sequencer, config register and result register.
// Read word: accept issues the slot read, S_READ registers the result, S_RESULT hands it to
// the output register once that is free, and the next word is taken back in S_IDLE.
// Add word: S_HASH registers the home slot, then S_PROBE walks from it, up to TABLE_SLOTS
// probes, before S_RESULT; a zero root goes straight to S_RESULT. One table read port,
// one probe a cycle. Reset: a clearing pass writes every slot empty; req_ready stays low
// meanwhile, config writes are taken throughout.
`include "keyed_usage_hash_aggregator_assert.svh"

module keyed_usage_hash_aggregator #(
  parameter int TABLE_SLOTS = khagg_pkg::TABLE_SLOTS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  khagg_pkg::item_t   req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output khagg_pkg::result_t rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IDX_W  = $clog2(TABLE_SLOTS);
  localparam int SLOT_W = khagg_pkg::SLOT_FIELD_W;

  khagg_pkg::state_t  state, state_next;
  logic               group_by_root_only;
  logic [IDX_W-1:0]   clr_idx, clr_idx_next;
  logic [IDX_W-1:0]   probe_idx, probe_idx_next;
  logic [IDX_W-1:0]   probe_cnt, probe_cnt_next;
  logic [IDX_W-1:0]   home_idx;
  khagg_pkg::result_t res, res_next;
  logic [63:0]        cur_root, cur_obj, cur_addr, cur_bytes;
  logic [63:0]        req_obj;
  logic               req_fire;
  logic               rsp_load;

  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  khagg_pkg::entry_t  mem_wdata, mem_rdata;
  logic [IDX_W-1:0]   hash_home;
  logic [64:0]        sum;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr == khagg_pkg::ADDR_GROUP_BY_ROOT_ONLY) ?
                  {31'b0, group_by_root_only} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_by_root_only <= 1'b0;
    end else if (psel && penable && pwrite) begin
      group_by_root_only <= pwdata[0];
    end
  end

  assign req_ready = (state == khagg_pkg::S_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign req_obj   = group_by_root_only ? 64'd0 : req.object_id;

  khagg_hash #(.TABLE_SLOTS(TABLE_SLOTS)) u_hash (
    .clk    (clk),
    .load   (req_fire),
    .root   (req.owner_root),
    .object (req_obj),
    .home   (hash_home)
  );

  khagg_mem #(.TABLE_SLOTS(TABLE_SLOTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign sum = {1'b0, mem_rdata.total} + {1'b0, cur_bytes};

  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    probe_idx_next = probe_idx;
    probe_cnt_next = probe_cnt;
    res_next       = res;
    mem_we         = 1'b0;
    mem_waddr      = probe_idx;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = probe_idx;
    rsp_load       = 1'b0;

    unique case (state)
      khagg_pkg::S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        clr_idx_next = clr_idx + IDX_W'(1);
        if (&clr_idx) begin
          state_next = khagg_pkg::S_IDLE;
        end
      end
      khagg_pkg::S_IDLE: begin
        if (req_fire) begin
          if (req.action) begin
            mem_re         = 1'b1;
            mem_raddr      = IDX_W'(req.slot_to_read);
            probe_idx_next = IDX_W'(req.slot_to_read);
            state_next     = khagg_pkg::S_READ;
          end else if (req.owner_root == 64'd0) begin
            res_next   = '{status: khagg_pkg::ST_ZERO_ROOT, default: '0};
            state_next = khagg_pkg::S_RESULT;
          end else begin
            state_next = khagg_pkg::S_HASH;
          end
        end
      end
      khagg_pkg::S_READ: begin
        if (mem_rdata.root == 64'd0) begin
          res_next = '{status: khagg_pkg::ST_EMPTY, slot_index: SLOT_W'(probe_idx),
                       default: '0};
        end else begin
          res_next = '{status: khagg_pkg::ST_USED, slot_index: SLOT_W'(probe_idx),
                       entry_root: mem_rdata.root, entry_object: mem_rdata.object,
                       entry_total: mem_rdata.total};
        end
        state_next = khagg_pkg::S_RESULT;
      end
      khagg_pkg::S_HASH: begin
        mem_re         = 1'b1;
        mem_raddr      = hash_home;
        probe_idx_next = hash_home;
        probe_cnt_next = '0;
        state_next     = khagg_pkg::S_PROBE;
      end
      khagg_pkg::S_PROBE: begin
        if (mem_rdata.root == 64'd0) begin
          mem_we    = 1'b1;
          mem_wdata = '{root: cur_root, object: cur_obj, last_extent: cur_addr,
                        total: cur_bytes};
          res_next  = '{status: khagg_pkg::ST_NEW, slot_index: SLOT_W'(probe_idx),
                        entry_root: cur_root, entry_object: cur_obj,
                        entry_total: cur_bytes};
          state_next = khagg_pkg::S_RESULT;
        end else if (mem_rdata.root == cur_root && mem_rdata.object == cur_obj) begin
          if (mem_rdata.last_extent == cur_addr) begin
            res_next = '{status: khagg_pkg::ST_SAME, slot_index: SLOT_W'(probe_idx),
                         entry_root: mem_rdata.root, entry_object: mem_rdata.object,
                         entry_total: mem_rdata.total};
          end else begin
            mem_we                = 1'b1;
            mem_wdata             = mem_rdata;
            mem_wdata.last_extent = cur_addr;
            mem_wdata.total       = sum[64] ? '1 : sum[63:0];
            res_next = '{status: khagg_pkg::ST_SUMMED, slot_index: SLOT_W'(probe_idx),
                         entry_root: mem_rdata.root, entry_object: mem_rdata.object,
                         entry_total: (sum[64] ? '1 : sum[63:0])};
          end
          state_next = khagg_pkg::S_RESULT;
        end else if (&probe_cnt) begin
          // every slot visited, key absent and no room
          res_next   = '{status: khagg_pkg::ST_FULL, slot_index: SLOT_W'(home_idx),
                         default: '0};
          state_next = khagg_pkg::S_RESULT;
        end else begin
          probe_idx_next = probe_idx + IDX_W'(1);
          probe_cnt_next = probe_cnt + IDX_W'(1);
          mem_re         = 1'b1;
          mem_raddr      = probe_idx + IDX_W'(1);
        end
      end
      khagg_pkg::S_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = khagg_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = khagg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= khagg_pkg::S_CLEAR;
      clr_idx <= '0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    probe_idx <= probe_idx_next;
    probe_cnt <= probe_cnt_next;
    res       <= res_next;
    if (state == khagg_pkg::S_HASH) begin
      home_idx <= hash_home;
    end
    if (req_fire) begin
      cur_root  <= req.owner_root;
      cur_obj   <= req_obj;
      cur_addr  <= req.extent_address;
      cur_bytes <= req.extent_bytes;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= res;
    end
  end

  `KHAGG_ASSERT_NOW(a_clear_blocks_req, state == khagg_pkg::S_CLEAR, !req_ready)
  `KHAGG_ASSERT_NOW(a_write_phase, mem_we, state == khagg_pkg::S_CLEAR || state == khagg_pkg::S_PROBE)
  `KHAGG_ASSERT_NOW(a_rsp_from_result, $rose(rsp_valid), $past(state == khagg_pkg::S_RESULT))
  `KHAGG_ASSERT_NEXT(a_probe_bounded, state == khagg_pkg::S_PROBE && (&probe_cnt), state == khagg_pkg::S_RESULT)

endmodule

FILE: tb/tb_keyed_usage_hash_aggregator.sv
// Self-checking testbench for the keyed usage hash aggregator: table model, driver, monitor.
`timescale 1ns / 100ps

module tb_keyed_usage_hash_aggregator;

  localparam int SLOTS = khagg_pkg::TABLE_SLOTS_DEFAULT;
  localparam int SW = khagg_pkg::SLOT_FIELD_W;
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam int POOL = 24;
  localparam int PHASE_WORDS = 200;
  localparam int BACKLOG_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  khagg_pkg::item_t req_word = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  khagg_pkg::result_t rsp_word;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  keyed_usage_hash_aggregator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req_word),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the hash table
  logic [63:0] tbl_root [SLOTS];
  logic [63:0] tbl_object [SLOTS];
  logic [63:0] tbl_last [SLOTS];
  logic [63:0] tbl_total [SLOTS];
  logic group_mode = 1'b0;

  khagg_pkg::item_t usage_words [$];
  khagg_pkg::result_t slot_reports [$];
  int errors = 0;
  int idle_left = 0;
  int stall_left = 0;
  int reports_seen = 0;
  bit calm = 1'b0;
  int unsigned mul_inv = 1;

  logic [63:0] pool_root [POOL];
  logic [63:0] pool_obj [POOL];
  logic [63:0] pool_addr [POOL];

  function automatic logic [SW-1:0] home_of(logic [63:0] root, logic [63:0] obj);
    logic [63:0] mix;
    mix = ({32'd0, khagg_pkg::HASH_MUL32} * root) ^ (khagg_pkg::HASH_MUL64 * obj);
    return SW'(mix & 64'(SLOTS - 1));
  endfunction

  function automatic khagg_pkg::result_t slot_report(khagg_pkg::status_t st,
                                                     logic [SW-1:0] idx, bit with_entry);
    khagg_pkg::result_t r;
    r = '0;
    r.status = st;
    r.slot_index = idx;
    if (with_entry) begin
      r.entry_root = tbl_root[idx];
      r.entry_object = tbl_object[idx];
      r.entry_total = tbl_total[idx];
    end
    return r;
  endfunction

  // applies one accepted word to the shadow table and returns the slot report
  function automatic khagg_pkg::result_t tally_word(khagg_pkg::item_t w);
    logic [63:0] obj;
    logic [SW-1:0] home;
    logic [SW-1:0] idx;
    if (w.action == ACT_READ) begin
      idx = w.slot_to_read;
      if (tbl_root[idx] == '0) return slot_report(khagg_pkg::ST_EMPTY, idx, 1'b0);
      return slot_report(khagg_pkg::ST_USED, idx, 1'b1);
    end
    if (w.owner_root == '0) return slot_report(khagg_pkg::ST_ZERO_ROOT, '0, 1'b0);
    obj = group_mode ? 64'd0 : w.object_id;
    home = home_of(w.owner_root, obj);
    idx = home;
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_root[idx] == '0) begin
        tbl_root[idx] = w.owner_root;
        tbl_object[idx] = obj;
        tbl_last[idx] = w.extent_address;
        tbl_total[idx] = w.extent_bytes;
        return slot_report(khagg_pkg::ST_NEW, idx, 1'b1);
      end
      if (tbl_root[idx] == w.owner_root && tbl_object[idx] == obj) begin
        if (tbl_last[idx] == w.extent_address)
          return slot_report(khagg_pkg::ST_SAME, idx, 1'b1);
        tbl_last[idx] = w.extent_address;
        if (tbl_total[idx] > ~w.extent_bytes) tbl_total[idx] = '1;
        else tbl_total[idx] = tbl_total[idx] + w.extent_bytes;
        return slot_report(khagg_pkg::ST_SUMMED, idx, 1'b1);
      end
      idx = SW'((32'(idx) + 1) % SLOTS);
    end
    return slot_report(khagg_pkg::ST_FULL, home, 1'b0);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] random_bytes();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) return ~64'($urandom_range(0, 65535));
    if (pick < 6) return 64'($urandom_range(0, 65535));
    return rand64();
  endfunction

  function automatic int gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return int'($urandom_range(1, 3));
    if (pick < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // low 12 bits of the root pick the home slot when the object id is zero
  function automatic logic [63:0] root_for_home(logic [SW-1:0] slot);
    logic [63:0] r;
    r = rand64();
    r[63] = 1'b1;
    r[SW-1:0] = SW'(32'(slot) * mul_inv);
    return r;
  endfunction

  task automatic push_add(logic [63:0] root, logic [63:0] obj, logic [63:0] addr,
                          logic [63:0] bytes);
    khagg_pkg::item_t w;
    w.action = ACT_ADD;
    w.extent_address = addr;
    w.owner_root = root;
    w.object_id = obj;
    w.extent_bytes = bytes;
    w.slot_to_read = SW'($urandom);
    usage_words.push_back(w);
  endtask

  task automatic push_read(logic [SW-1:0] slot);
    khagg_pkg::item_t w;
    w.action = ACT_READ;
    w.extent_address = rand64();
    w.owner_root = rand64();
    w.object_id = rand64();
    w.extent_bytes = rand64();
    w.slot_to_read = slot;
    usage_words.push_back(w);
  endtask

  task automatic refresh_pool();
    for (int j = 0; j < POOL; j++) begin
      // groups of three keys share one home slot, forcing probe chains
      if (j % 3 == 0) begin
        pool_root[j] = rand64();
        pool_obj[j] = rand64();
      end else begin
        pool_root[j] = pool_root[j-1] + (64'd1 << SW);
        pool_obj[j] = pool_obj[j-1];
      end
      pool_addr[j] = rand64();
    end
  endtask

  function automatic khagg_pkg::item_t random_word();
    khagg_pkg::item_t w;
    int unsigned pick;
    int unsigned k;
    w.action = ACT_ADD;
    w.extent_address = rand64();
    w.owner_root = rand64();
    w.object_id = rand64();
    w.extent_bytes = random_bytes();
    w.slot_to_read = SW'($urandom);
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, POOL - 1);
    if (pick < 12) begin
      w.action = ACT_READ;
      if (pick < 8) w.slot_to_read = home_of(pool_root[k], group_mode ? 64'd0 : pool_obj[k]);
    end else if (pick < 16) begin
      w.owner_root = '0;
    end else if (pick >= 22) begin
      w.owner_root = pool_root[k];
      w.object_id = pool_obj[k];
      if ($urandom_range(0, 3) == 0) w.extent_address = pool_addr[k];
      pool_addr[k] = w.extent_address;
    end
    return w;
  endfunction

  task automatic wait_idle();
    while (usage_words.size() != 0 || req_valid || slot_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_group_mode(logic value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= khagg_pkg::ADDR_GROUP_BY_ROOT_ONLY;
    pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    group_mode = value;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) slot_reports.push_back(tally_word(req_word));
      if (!req_valid || req_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          req_valid <= 1'b0;
        end else if (usage_words.size() > 0) begin
          req_word <= usage_words.pop_front();
          req_valid <= 1'b1;
          if (!calm) idle_left = gap_len();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (slot_reports.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none actual %h", $time, rsp_word);
        end else begin
          khagg_pkg::result_t want;
          want = slot_reports.pop_front();
          check_field("status", 64'(want.status), 64'(rsp_word.status));
          check_field("slot_index", 64'(want.slot_index), 64'(rsp_word.slot_index));
          check_field("entry_root", want.entry_root, rsp_word.entry_root);
          check_field("entry_object", want.entry_object, rsp_word.entry_object);
          check_field("entry_total", want.entry_total, rsp_word.entry_total);
        end
        reports_seen++;
        // long backpressure so the block backs up into its input
        if (reports_seen == 150 || reports_seen == 500) stall_left = BACKLOG_CYCLES;
        else if (!calm) stall_left = gap_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [63:0] root_a;
    logic [63:0] root_b;
    logic [63:0] ones;
    ones = '1;
    tbl_root = '{default: '0};
    tbl_object = '{default: '0};
    tbl_last = '{default: '0};
    tbl_total = '{default: '0};
    for (int r = 1; r < SLOTS; r += 2)
      if (SW'(khagg_pkg::HASH_MUL32 * 32'(r)) == SW'(1)) mul_inv = r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_group_mode(1'b0);

    // directed: empty reads, zero root, wrapping probe, same extent, saturation
    root_a = root_for_home(SW'(SLOTS - 1));
    root_b = root_for_home(SW'(SLOTS - 1));
    push_read('0);
    push_read(SW'(SLOTS - 1));
    push_add('0, ones, ones, ones);
    push_add(root_a, '0, '0, '0);
    push_add(root_b, '0, ones, ones);
    push_add(root_b, '0, ones, 64'd3);
    push_add(root_b, '0, 64'd1, 64'd1);
    push_add(root_a, '0, 64'd5, ones);
    push_read(SW'(SLOTS - 1));
    push_read('0);
    push_add(ones, ones, ones, ones);
    push_add(64'd1, 64'd5, 64'd1, 64'd100);
    push_add(64'd1, '0, 64'd2, 64'd7);
    wait_idle();
    write_group_mode(1'b1);
    // object id is dropped, so these fold onto the (1, 0) key
    push_add(64'd1, 64'd5, 64'd3, 64'd9);
    push_add(64'd1, 64'd123, 64'd3, 64'd9);
    push_add(ones, '0, '0, ones);
    push_read(home_of(64'd1, '0));
    push_add('0, 64'd77, 64'd1, 64'd1);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      write_group_mode(phase[0]);
      calm = (phase == 2);
      refresh_pool();
      for (int i = 0; i < PHASE_WORDS; i++) usage_words.push_back(random_word());
      wait_idle();
    end

    // tail: known key, random read, zero root and fresh keys back to back
    calm = 1'b1;
    write_group_mode(1'b0);
    push_add(rand64(), rand64(), rand64(), rand64());
    push_add(root_a, '0, rand64(), random_bytes());
    push_read(SW'($urandom));
    push_add('0, rand64(), rand64(), rand64());
    push_add(rand64(), '0, rand64(), rand64());
    wait_idle();

    repeat (8) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
